// File: rtl/core/btp_pkg.sv
package btp_pkg;

   localparam int MAX_BOUNCES  = 16;
   localparam int FRAC_BITS    = 10;
   localparam int CORDIC_STEPS = 16;

   // datapath widths
   localparam int CY_W = 43;
   localparam int DX_W = 62;
   localparam int AR_W = 64;
   localparam int SQ_W = 48;
   localparam int Z_W  = 35;
   localparam int CS_W = 18;
   localparam int B_W  = (16 + FRAC_BITS + 1 > 24) ? 16 + FRAC_BITS + 1 : 24;
   localparam int CNT_W = 7;
   localparam int ATAN_IDX_W = 5;
   localparam int BNC_W = 7;

   localparam logic [31:0] ATAN_Q30 [24] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
      32'd128
   };

   localparam logic signed [Z_W-1:0]  PI_Q30      = 35'sd3373259426;
   localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [Z_W-1:0]  ONE_Q30     = 35'sd1073741824;
   localparam logic signed [Z_W-1:0]  ROUND_Q16   = 35'sd8192;
   localparam logic signed [15:0]     PI_Q13      = 16'sd25736;
   localparam logic [DX_W-1:0]        SEG_LIMIT   = 62'd4194304;
   localparam logic signed [DX_W-1:0] Y_CLAMP     = 62'sd1099511627776;
   localparam logic [20:0]            LEN_MAX     = 21'h1FFFFF;
   localparam logic [15:0]            FRAMES_MAX  = 16'hFFFF;
   localparam int                     FRAME_SCALE = 60 * 256;
   localparam logic [15:0]            LW_RESET    = 16'd1109;
   localparam logic [15:0]            RW_RESET    = 16'd25515;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } arith_op_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BOUNCE_LIMIT,
      STATUS_ZERO_SLOPE,
      STATUS_ZERO_SPEED
   } status_type;

   typedef enum logic [0:0] {
      CSR_LEFT_WALL,
      CSR_RIGHT_WALL
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_CROSS_MUL,
      ST_CROSS_DIV,
      ST_CROSS_CHK,
      ST_WALL_MUL,
      ST_WALL_DIV,
      ST_SEG_CHK,
      ST_SEG_MULX,
      ST_SEG_MULY,
      ST_SEG_SQRT,
      ST_WALL_UPD,
      ST_FRM_CHK,
      ST_FRM_MUL,
      ST_FRM_DIV,
      ST_RESP
   } fsm_state_type;

   typedef struct packed {
      logic            start;
      arith_op_type    op;
      logic [AR_W-1:0] a;
      logic [B_W-1:0]  b;
   } arith_cmd_type;

   typedef struct packed {
      logic            done;
      logic [AR_W-1:0] result;
   } arith_rsp_type;

   typedef struct packed {
      logic                   done;
      logic signed [CS_W-1:0] cos_val;
      logic signed [CS_W-1:0] sin_val;
   } cordic_rsp_type;

endpackage

// File: rtl/core/btp_arith.sv
module btp_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  btp_pkg::arith_cmd_type cmd,
   output btp_pkg::arith_rsp_type rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   btp_pkg::arith_op_type        op_ff, op_in;
   logic [btp_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [btp_pkg::AR_W-1:0]     a_ff, a_in;
   logic [btp_pkg::B_W-1:0]      b_ff, b_in;
   logic [btp_pkg::AR_W-1:0]     acc_ff, acc_in;
   logic [btp_pkg::B_W:0]        rem_ff, rem_in;
   logic [btp_pkg::SQ_W-1:0]     bit_ff, bit_in;

   logic [btp_pkg::B_W:0]        rem_sh;
   logic [btp_pkg::SQ_W-1:0]     sq_t;

   assign rem_sh = {rem_ff[btp_pkg::B_W-1:0], a_ff[btp_pkg::AR_W-1]};
   assign sq_t   = acc_ff[btp_pkg::SQ_W-1:0] + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      bit_in  = bit_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         a_in    = cmd.a;
         b_in    = cmd.b;
         acc_in  = '0;
         rem_in  = '0;
         bit_in  = btp_pkg::SQ_W'(1) << (btp_pkg::SQ_W - 2);
         case (cmd.op)
            btp_pkg::OP_MUL:  cnt_in = btp_pkg::CNT_W'(btp_pkg::B_W - 1);
            btp_pkg::OP_DIV:  cnt_in = btp_pkg::CNT_W'(btp_pkg::AR_W - 1);
            btp_pkg::OP_SQRT: cnt_in = btp_pkg::CNT_W'(btp_pkg::SQ_W / 2 - 1);
            default:          cnt_in = '0;
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            btp_pkg::OP_MUL: begin
               acc_in = {acc_ff[btp_pkg::AR_W-2:0], 1'b0} +
                        (b_ff[btp_pkg::B_W-1] ? a_ff : '0);
               b_in   = {b_ff[btp_pkg::B_W-2:0], 1'b0};
            end
            btp_pkg::OP_DIV: begin
               a_in = {a_ff[btp_pkg::AR_W-2:0], 1'b0};
               if (rem_sh >= {1'b0, b_ff}) begin
                  rem_in = rem_sh - {1'b0, b_ff};
                  acc_in = {acc_ff[btp_pkg::AR_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  acc_in = {acc_ff[btp_pkg::AR_W-2:0], 1'b0};
               end
            end
            btp_pkg::OP_SQRT: begin
               bit_in = bit_ff >> 2;
               if (a_ff[btp_pkg::SQ_W-1:0] >= sq_t) begin
                  a_in   = {a_ff[btp_pkg::AR_W-1:btp_pkg::SQ_W],
                            a_ff[btp_pkg::SQ_W-1:0] - sq_t};
                  acc_in = btp_pkg::AR_W'((acc_ff[btp_pkg::SQ_W-1:0] >> 1) + bit_ff);
               end else begin
                  acc_in = acc_ff >> 1;
               end
            end
            default: acc_in = acc_ff;
         endcase
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;

endmodule

// File: rtl/core/btp_cordic.sv
module btp_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [15:0]      heading,
   output btp_pkg::cordic_rsp_type rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic                             flip_ff, flip_in;
   logic [btp_pkg::ATAN_IDX_W-1:0]   cnt_ff, cnt_in;
   logic signed [btp_pkg::Z_W-1:0]   x_ff, x_in;
   logic signed [btp_pkg::Z_W-1:0]   y_ff, y_in;
   logic signed [btp_pkg::Z_W-1:0]   z_ff, z_in;

   logic signed [btp_pkg::Z_W-1:0]   z0;
   logic signed [btp_pkg::Z_W-1:0]   xs;
   logic signed [btp_pkg::Z_W-1:0]   ys;
   logic signed [btp_pkg::Z_W-1:0]   atan_val;
   logic signed [btp_pkg::Z_W-1:0]   xr;
   logic signed [btp_pkg::Z_W-1:0]   yr;

   assign z0       = {{(btp_pkg::Z_W-33){heading[15]}}, heading, 17'b0};
   assign xs       = x_ff >>> cnt_ff;
   assign ys       = y_ff >>> cnt_ff;
   assign atan_val = $signed({3'b000, btp_pkg::ATAN_Q30[cnt_ff]});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = btp_pkg::ONE_Q30;
         y_in    = '0;
         if (z0 > btp_pkg::HALF_PI_Q30) begin
            z_in    = z0 - btp_pkg::PI_Q30;
            flip_in = 1'b1;
         end else if (z0 < -btp_pkg::HALF_PI_Q30) begin
            z_in    = z0 + btp_pkg::PI_Q30;
            flip_in = 1'b1;
         end else begin
            z_in    = z0;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (!z_ff[btp_pkg::Z_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_val;
         end
         if (cnt_ff == btp_pkg::ATAN_IDX_W'(btp_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff <= flip_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   // sign fold, then round half up to q16
   assign xr = (flip_ff ? -x_ff : x_ff) + btp_pkg::ROUND_Q16;
   assign yr = (flip_ff ? -y_ff : y_ff) + btp_pkg::ROUND_Q16;

   assign rsp.done    = done_ff;
   assign rsp.cos_val = xr[31:14];
   assign rsp.sin_val = yr[31:14];

endmodule

// File: rtl/core/bounce_trajectory_predictor.sv
// Bounce trajectory predictor.
// Request channel (req_*): heading, target line, start position and speed, one
// transfer per prediction. Response channel (rsp_*): crossing x, path length,
// travel frames, bounce count and status, one transfer per request.
// csr_*: left and right wall positions; the user must write them only while the
// block is idle, as the block itself does not enforce it. Sequence: CORDIC for the
// heading, then one pass per wall bounce, then the final crossing segment and the
// frame count.
// One request is worked on at a time; req_ready is high only when idle.
// Every multiply, divide and square root runs on one shared bit-serial unit.
// The response is held in registers with rsp_valid high until rsp_ready;
// a stalled receiver holds the block in that state and no new request is taken.
// Reset returns the sequencer to idle, drops rsp_valid and restores the wall
// registers to their default positions.
module bounce_trajectory_predictor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_heading,
   input  logic signed [16:0] req_target_line,
   input  logic signed [16:0] req_start_x,
   input  logic signed [16:0] req_start_y,
   input  logic [15:0]        req_speed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_predicted_x,
   output logic [20:0]        rsp_path_length,
   output logic [15:0]        rsp_travel_frames,
   output logic [6:0]         rsp_bounce_count,
   output logic [1:0]         rsp_status,
   input  logic               csr_write_en,
   input  logic [0:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   localparam int CY_W = btp_pkg::CY_W;
   localparam int DX_W = btp_pkg::DX_W;
   localparam int AR_W = btp_pkg::AR_W;
   localparam int B_W  = btp_pkg::B_W;
   localparam int CS_W = btp_pkg::CS_W;
   localparam int FB   = btp_pkg::FRAC_BITS;

   btp_pkg::fsm_state_type     state_ff, state_in;
   logic                       pend_ff, pend_in;
   logic [15:0]                lw_ff, lw_in;
   logic [15:0]                rw_ff, rw_in;
   logic signed [15:0]         head_ff, head_in;
   logic signed [16:0]         ty_ff, ty_in;
   logic signed [16:0]         cx_ff, cx_in;
   logic signed [CY_W-1:0]     cy_ff, cy_in;
   logic [15:0]                speed_ff, speed_in;
   logic signed [CS_W-1:0]     c_ff, c_in;
   logic signed [CS_W-1:0]     s_ff, s_in;
   logic signed [DX_W-1:0]     seg_x_ff, seg_x_in;
   logic signed [DX_W-1:0]     seg_y_ff, seg_y_in;
   logic [AR_W-1:0]            prod_ff, prod_in;
   logic                       neg_ff, neg_in;
   logic                       cross_ff, cross_in;
   logic [15:0]                wall_ff, wall_in;
   logic [16:0]                nx_ff, nx_in;
   logic [20:0]                len_ff, len_in;
   logic [15:0]                frames_ff, frames_in;
   logic [btp_pkg::BNC_W-1:0]  bounces_ff, bounces_in;
   btp_pkg::status_type        status_ff, status_in;

   btp_pkg::arith_cmd_type     arith_cmd;
   btp_pkg::arith_rsp_type     arith_rsp;
   logic                       cordic_start;
   btp_pkg::cordic_rsp_type    cordic_rsp;

   logic signed [CY_W-1:0]     ty_ext;
   logic signed [CY_W-1:0]     dy;
   logic [CY_W-1:0]            dy_mag;
   logic [CS_W-1:0]            c_abs;
   logic [CS_W-1:0]            s_abs;
   logic signed [DX_W-1:0]     cx_ext;
   logic signed [DX_W-1:0]     cy_ext;
   logic signed [DX_W-1:0]     nx;
   logic signed [DX_W-1:0]     lw_ext;
   logic signed [DX_W-1:0]     rw_ext;
   logic [15:0]                wall_sel;
   logic signed [DX_W-1:0]     wall_dx;
   logic [DX_W-1:0]            sx_abs;
   logic [DX_W-1:0]            sy_abs;
   logic                       seg_big;
   logic signed [DX_W-1:0]     cy_sum;
   logic signed [DX_W-1:0]     cy_clamped;
   logic [AR_W-1:0]            q_val;
   logic [24:0]                len_sum;
   logic [AR_W-1:0]            sq_sum;
   logic [15+FB:0]             spd_den;
   logic [14+FB:0]             spd_half;
   logic                       zero_slope;

   btp_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .heading (head_ff),
      .rsp     (cordic_rsp)
   );

   btp_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (arith_cmd),
      .rsp   (arith_rsp)
   );

   assign ty_ext   = {{(CY_W-17){ty_ff[16]}}, ty_ff};
   assign dy       = ty_ext - cy_ff;
   assign dy_mag   = dy[CY_W-1] ? -dy : dy;
   assign c_abs    = c_ff[CS_W-1] ? -c_ff : c_ff;
   assign s_abs    = s_ff[CS_W-1] ? -s_ff : s_ff;
   assign cx_ext   = {{(DX_W-17){cx_ff[16]}}, cx_ff};
   assign cy_ext   = {{(DX_W-CY_W){cy_ff[CY_W-1]}}, cy_ff};
   assign nx       = seg_x_ff + cx_ext;
   assign lw_ext   = $signed({{(DX_W-16){1'b0}}, lw_ff});
   assign rw_ext   = $signed({{(DX_W-16){1'b0}}, rw_ff});
   assign wall_sel = (nx < lw_ext) ? lw_ff : rw_ff;
   assign wall_dx  = $signed({{(DX_W-16){1'b0}}, wall_sel}) - cx_ext;
   assign sx_abs   = seg_x_ff[DX_W-1] ? -seg_x_ff : seg_x_ff;
   assign sy_abs   = seg_y_ff[DX_W-1] ? -seg_y_ff : seg_y_ff;
   assign seg_big  = (sx_abs > btp_pkg::SEG_LIMIT) || (sy_abs > btp_pkg::SEG_LIMIT);
   assign cy_sum   = seg_y_ff + cy_ext;
   assign q_val    = neg_ff ? -arith_rsp.result : arith_rsp.result;
   assign len_sum  = {4'b0, len_ff} + arith_rsp.result[24:0];
   assign sq_sum   = prod_ff + arith_rsp.result;
   assign spd_den  = {speed_ff, {FB{1'b0}}};
   assign spd_half = {speed_ff, {(FB-1){1'b0}}};
   assign zero_slope = (head_ff == '0) || (head_ff == btp_pkg::PI_Q13) ||
                       (head_ff == -btp_pkg::PI_Q13) || (cordic_rsp.sin_val == '0);

   always_comb begin
      if (cy_sum > btp_pkg::Y_CLAMP) begin
         cy_clamped = btp_pkg::Y_CLAMP;
      end else if (cy_sum < -btp_pkg::Y_CLAMP) begin
         cy_clamped = -btp_pkg::Y_CLAMP;
      end else begin
         cy_clamped = cy_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btp_pkg::ST_IDLE;
         pend_ff  <= 1'b0;
         lw_ff    <= btp_pkg::LW_RESET;
         rw_ff    <= btp_pkg::RW_RESET;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         lw_ff    <= lw_in;
         rw_ff    <= rw_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff    <= head_in;
      ty_ff      <= ty_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      speed_ff   <= speed_in;
      c_ff       <= c_in;
      s_ff       <= s_in;
      seg_x_ff   <= seg_x_in;
      seg_y_ff   <= seg_y_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      cross_ff   <= cross_in;
      wall_ff    <= wall_in;
      nx_ff      <= nx_in;
      len_ff     <= len_in;
      frames_ff  <= frames_in;
      bounces_ff <= bounces_in;
      status_ff  <= status_in;
   end

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      lw_in        = lw_ff;
      rw_in        = rw_ff;
      head_in      = head_ff;
      ty_in        = ty_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      speed_in     = speed_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      seg_x_in     = seg_x_ff;
      seg_y_in     = seg_y_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      cross_in     = cross_ff;
      wall_in      = wall_ff;
      nx_in        = nx_ff;
      len_in       = len_ff;
      frames_in    = frames_ff;
      bounces_in   = bounces_ff;
      status_in    = status_ff;
      arith_cmd    = '0;
      cordic_start = 1'b0;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;

      if (csr_write_en) begin
         case (btp_pkg::csr_index_type'(csr_index))
            btp_pkg::CSR_LEFT_WALL:  lw_in = csr_write_data;
            btp_pkg::CSR_RIGHT_WALL: rw_in = csr_write_data;
            default:                 lw_in = lw_ff;
         endcase
      end

      case (state_ff)
         btp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               head_in    = req_heading;
               ty_in      = req_target_line;
               cx_in      = req_start_x;
               cy_in      = {{(CY_W-17){req_start_y[16]}}, req_start_y};
               speed_in   = req_speed;
               len_in     = '0;
               nx_in      = '0;
               frames_in  = '0;
               bounces_in = '0;
               status_in  = btp_pkg::STATUS_OK;
               pend_in    = 1'b0;
               state_in   = btp_pkg::ST_CORDIC;
            end
         end
         btp_pkg::ST_CORDIC: begin
            if (!pend_ff) begin
               cordic_start = 1'b1;
               pend_in      = 1'b1;
            end else if (cordic_rsp.done) begin
               pend_in = 1'b0;
               c_in    = cordic_rsp.cos_val;
               s_in    = cordic_rsp.sin_val;
               if (zero_slope) begin
                  status_in = btp_pkg::STATUS_ZERO_SLOPE;
                  state_in  = btp_pkg::ST_RESP;
               end else begin
                  state_in  = btp_pkg::ST_CROSS_MUL;
               end
            end
         end
         btp_pkg::ST_CROSS_MUL: begin
            arith_cmd.op = btp_pkg::OP_MUL;
            arith_cmd.a  = AR_W'(dy_mag);
            arith_cmd.b  = B_W'(c_abs[CS_W-2:0]);
            if (!pend_ff) begin
               arith_cmd.start = 1'b1;
               pend_in  = 1'b1;
               neg_in   = dy[CY_W-1] ^ c_ff[CS_W-1] ^ s_ff[CS_W-1];
               seg_y_in = {{(DX_W-CY_W){dy[CY_W-1]}}, dy};
            end else if (arith_rsp.done) begin
               pend_in  = 1'b0;
               prod_in  = arith_rsp.result;
               state_in = btp_pkg::ST_CROSS_DIV;
            end
         end
         btp_pkg::ST_CROSS_DIV: begin
            arith_cmd.op = btp_pkg::OP_DIV;
            arith_cmd.a  = prod_ff + AR_W'(s_abs[CS_W-2:1]);
            arith_cmd.b  = B_W'(s_abs[CS_W-2:0]);
            if (!pend_ff) begin
               arith_cmd.start = 1'b1;
               pend_in = 1'b1;
            end else if (arith_rsp.done) begin
               pend_in  = 1'b0;
               seg_x_in = q_val[DX_W-1:0];
               state_in = btp_pkg::ST_CROSS_CHK;
            end
         end
         btp_pkg::ST_CROSS_CHK: begin
            if (nx >= lw_ext && nx <= rw_ext) begin
               nx_in    = nx[16:0];
               cross_in = 1'b1;
               state_in = btp_pkg::ST_SEG_CHK;
            end else if (bounces_ff >= btp_pkg::BNC_W'(btp_pkg::MAX_BOUNCES) ||
                         c_ff == '0) begin
               status_in = btp_pkg::STATUS_BOUNCE_LIMIT;
               nx_in     = '0;
               len_in    = '0;
               frames_in = '0;
               state_in  = btp_pkg::ST_RESP;
            end else begin
               wall_in  = wall_sel;
               seg_x_in = wall_dx;
               state_in = btp_pkg::ST_WALL_MUL;
            end
         end
         btp_pkg::ST_WALL_MUL: begin
            arith_cmd.op = btp_pkg::OP_MUL;
            arith_cmd.a  = AR_W'(sx_abs);
            arith_cmd.b  = B_W'(s_abs[CS_W-2:0]);
            if (!pend_ff) begin
               arith_cmd.start = 1'b1;
               pend_in = 1'b1;
               neg_in  = seg_x_ff[DX_W-1] ^ s_ff[CS_W-1] ^ c_ff[CS_W-1];
            end else if (arith_rsp.done) begin
               pend_in  = 1'b0;
               prod_in  = arith_rsp.result;
               state_in = btp_pkg::ST_WALL_DIV;
            end
         end
         btp_pkg::ST_WALL_DIV: begin
            arith_cmd.op = btp_pkg::OP_DIV;
            arith_cmd.a  = prod_ff + AR_W'(c_abs[CS_W-2:1]);
            arith_cmd.b  = B_W'(c_abs[CS_W-2:0]);
            if (!pend_ff) begin
               arith_cmd.start = 1'b1;
               pend_in = 1'b1;
            end else if (arith_rsp.done) begin
               pend_in  = 1'b0;
               seg_y_in = q_val[DX_W-1:0];
               cross_in = 1'b0;
               state_in = btp_pkg::ST_SEG_CHK;
            end
         end
         btp_pkg::ST_SEG_CHK: begin
            if (seg_big) begin
               len_in   = btp_pkg::LEN_MAX;
               state_in = cross_ff ? btp_pkg::ST_FRM_CHK : btp_pkg::ST_WALL_UPD;
            end else begin
               state_in = btp_pkg::ST_SEG_MULX;
            end
         end
         btp_pkg::ST_SEG_MULX: begin
            arith_cmd.op = btp_pkg::OP_MUL;
            arith_cmd.a  = AR_W'(sx_abs[22:0]);
            arith_cmd.b  = B_W'(sx_abs[22:0]);
            if (!pend_ff) begin
               arith_cmd.start = 1'b1;
               pend_in = 1'b1;
            end else if (arith_rsp.done) begin
               pend_in  = 1'b0;
               prod_in  = arith_rsp.result;
               state_in = btp_pkg::ST_SEG_MULY;
            end
         end
         btp_pkg::ST_SEG_MULY: begin
            arith_cmd.op = btp_pkg::OP_MUL;
            arith_cmd.a  = AR_W'(sy_abs[22:0]);
            arith_cmd.b  = B_W'(sy_abs[22:0]);
            if (!pend_ff) begin
               arith_cmd.start = 1'b1;
               pend_in = 1'b1;
            end else if (arith_rsp.done) begin
               pend_in  = 1'b0;
               prod_in  = sq_sum;
               state_in = btp_pkg::ST_SEG_SQRT;
            end
         end
         btp_pkg::ST_SEG_SQRT: begin
            arith_cmd.op = btp_pkg::OP_SQRT;
            arith_cmd.a  = prod_ff;
            if (!pend_ff) begin
               arith_cmd.start = 1'b1;
               pend_in = 1'b1;
            end else if (arith_rsp.done) begin
               pend_in  = 1'b0;
               len_in   = (len_sum > 25'(btp_pkg::LEN_MAX)) ? btp_pkg::LEN_MAX :
                          len_sum[20:0];
               state_in = cross_ff ? btp_pkg::ST_FRM_CHK : btp_pkg::ST_WALL_UPD;
            end
         end
         btp_pkg::ST_WALL_UPD: begin
            cy_in      = cy_clamped[CY_W-1:0];
            cx_in      = $signed({1'b0, wall_ff});
            c_in       = -c_ff;
            bounces_in = bounces_ff + 1'b1;
            state_in   = btp_pkg::ST_CROSS_MUL;
         end
         btp_pkg::ST_FRM_CHK: begin
            if (speed_ff == '0) begin
               status_in = btp_pkg::STATUS_ZERO_SPEED;
               frames_in = btp_pkg::FRAMES_MAX;
               state_in  = btp_pkg::ST_RESP;
            end else begin
               state_in  = btp_pkg::ST_FRM_MUL;
            end
         end
         btp_pkg::ST_FRM_MUL: begin
            arith_cmd.op = btp_pkg::OP_MUL;
            arith_cmd.a  = AR_W'(len_ff);
            arith_cmd.b  = B_W'(btp_pkg::FRAME_SCALE);
            if (!pend_ff) begin
               arith_cmd.start = 1'b1;
               pend_in = 1'b1;
            end else if (arith_rsp.done) begin
               pend_in  = 1'b0;
               prod_in  = arith_rsp.result;
               state_in = btp_pkg::ST_FRM_DIV;
            end
         end
         btp_pkg::ST_FRM_DIV: begin
            arith_cmd.op = btp_pkg::OP_DIV;
            arith_cmd.a  = prod_ff + AR_W'(spd_half);
            arith_cmd.b  = B_W'(spd_den);
            if (!pend_ff) begin
               arith_cmd.start = 1'b1;
               pend_in = 1'b1;
            end else if (arith_rsp.done) begin
               pend_in   = 1'b0;
               frames_in = (|arith_rsp.result[AR_W-1:16]) ? btp_pkg::FRAMES_MAX :
                           arith_rsp.result[15:0];
               status_in = btp_pkg::STATUS_OK;
               state_in  = btp_pkg::ST_RESP;
            end
         end
         btp_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = btp_pkg::ST_IDLE;
            end
         end
         default: state_in = btp_pkg::ST_IDLE;
      endcase
   end

   assign rsp_predicted_x   = $signed(nx_ff);
   assign rsp_path_length   = len_ff;
   assign rsp_travel_frames = frames_ff;
   assign rsp_bounce_count  = bounces_ff;
   assign rsp_status        = status_ff;

endmodule
